>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker module
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/dsmp_pkg.sv
// constants for the decimal seconds to milliseconds parser
// no dependencies; used by the top level and its checker
package dsmp_pkg;

  // field widths
  localparam int unsigned CharW    = 8;
  localparam int unsigned MsW      = 32;
  localparam int unsigned WholeW   = 23;
  localparam int unsigned FracW    = 10;
  localparam int unsigned FracCntW = 2;
  localparam int unsigned DigitW   = 4;

  // limits and scale
  localparam logic [WholeW-1:0]   WholeLimit = 23'd4294967;
  localparam logic [FracCntW-1:0] FracDigits = 2'd3;
  localparam logic [9:0]          MsPerSec   = 10'd1000;

  // character codes
  localparam logic [CharW-1:0] CharNul  = 8'h00;
  localparam logic [CharW-1:0] CharDot  = 8'h2e;
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;

endpackage

>>> hw/rtl/decimal_seconds_to_ms_parser.sv
// top level of the decimal seconds to milliseconds parser
// depends on dsmp_pkg
//
// Takes one ASCII byte per cycle on the slave stream while tready is high
// and, at each NUL byte, returns one beat holding status in tuser
// (1 = malformed or overflowed) and the value in milliseconds in tdata
// (zero on error). Text is digits, an optional '.', and up to three
// fraction digits; the integer part may not exceed 4294967. Each accepted
// digit advances the parse state by one multiply-by-ten-and-add step, and
// at the terminator the total (seconds times 1000 plus the scaled
// fraction) is formed and registered into the output register, or into
// the skid stage while the output is stalled. An output register backed
// by a one-beat skid stage lets input bytes keep flowing while a result
// waits; tready drops only when both hold results.
module decimal_seconds_to_ms_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // slave stream, tdata: [7:0] character
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [dsmp_pkg::CharW-1:0] s_axis_tdata_i,
  // master stream, tdata: [31:0] milliseconds
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [dsmp_pkg::MsW-1:0] m_axis_tdata_o,
  // master stream, tuser: [0] status
  output logic                     m_axis_tuser_o
);
  import dsmp_pkg::*;

  typedef enum logic [1:0] {
    PhFirst = 2'd0,
    PhWhole = 2'd1,
    PhFrac  = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [WholeW-1:0]     whole_q, whole_d;
  logic [FracW-1:0]      frac_q, frac_d;
  logic [FracCntW-1:0]   fcnt_q, fcnt_d;
  logic                  failed_q, failed_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_err_q, out_err_d;
  logic [MsW-1:0]        out_ms_q, out_ms_d;
  logic                  skid_valid_q, skid_valid_d;
  logic                  skid_err_q, skid_err_d;
  logic [MsW-1:0]        skid_ms_q, skid_ms_d;

  logic                  accept;
  logic                  is_term;
  logic                  is_digit;
  logic [DigitW-1:0]     digit;
  logic [WholeW+2:0]     whole_next;
  logic [FracW-1:0]      frac_next;
  logic [FracW-1:0]      frac_scaled;
  logic [MsW:0]          total;
  logic                  res_err;
  logic [MsW-1:0]        res_ms;
  logic                  res_valid;

  assign s_axis_tready_o = ~skid_valid_q;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // character decode
  assign is_term  = (s_axis_tdata_i == CharNul);
  assign is_digit = (s_axis_tdata_i >= CharZero) && (s_axis_tdata_i <= CharNine);
  assign digit    = is_digit ? DigitW'(s_axis_tdata_i - CharZero) : '0;

  // one decimal step on the integer and fraction accumulators
  assign whole_next = (WholeW+3)'(whole_q) * (WholeW+3)'(10) + (WholeW+3)'(digit);
  assign frac_next  = FracW'((FracW+4)'(frac_q) * (FracW+4)'(10) + (FracW+4)'(digit));

  // scale a short fraction up to three digits
  always_comb begin
    unique case (fcnt_q)
      2'd1:    frac_scaled = FracW'(frac_q * FracW'(100));
      2'd2:    frac_scaled = FracW'(frac_q * FracW'(10));
      2'd3:    frac_scaled = frac_q;
      default: frac_scaled = '0;
    endcase
  end

  // result at the terminator
  assign total   = (MsW+1)'(whole_q) * (MsW+1)'(MsPerSec) + (MsW+1)'(frac_scaled);
  assign res_err = failed_q || (phase_q == PhFirst) ||
                   ((phase_q != PhWhole) && (phase_q != PhFrac)) || total[MsW];
  assign res_ms  = res_err ? '0 : total[MsW-1:0];
  assign res_valid = accept & is_term;

  // parse state update
  always_comb begin
    phase_d  = phase_q;
    whole_d  = whole_q;
    frac_d   = frac_q;
    fcnt_d   = fcnt_q;
    failed_d = failed_q;
    if (accept) begin
      if (is_term) begin
        phase_d  = PhFirst;
        whole_d  = '0;
        frac_d   = '0;
        fcnt_d   = '0;
        failed_d = 1'b0;
      end else if (!failed_q) begin
        unique case (phase_q)
          PhFirst: begin
            if (is_digit) begin
              whole_d = WholeW'(digit);
              phase_d = PhWhole;
            end else begin
              failed_d = 1'b1;
            end
          end
          PhWhole: begin
            if (is_digit) begin
              if (whole_next > (WholeW+3)'(WholeLimit)) begin
                failed_d = 1'b1;
              end else begin
                whole_d = whole_next[WholeW-1:0];
              end
            end else if (s_axis_tdata_i == CharDot) begin
              phase_d = PhFrac;
            end else begin
              failed_d = 1'b1;
            end
          end
          PhFrac: begin
            if (is_digit && (fcnt_q < FracDigits)) begin
              frac_d = frac_next;
              fcnt_d = fcnt_q + 2'd1;
            end else begin
              failed_d = 1'b1;
            end
          end
          default: failed_d = 1'b1;
        endcase
      end
    end
  end

  // output register with skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_err_d    = out_err_q;
    out_ms_d     = out_ms_q;
    skid_valid_d = skid_valid_q;
    skid_err_d   = skid_err_q;
    skid_ms_d    = skid_ms_q;
    if (out_valid_q && !m_axis_tready_i) begin
      if (res_valid) begin
        skid_valid_d = 1'b1;
        skid_err_d   = res_err;
        skid_ms_d    = res_ms;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_err_d    = skid_err_q;
      out_ms_d     = skid_ms_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = res_valid;
      out_err_d   = res_err;
      out_ms_d    = res_ms;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhFirst;
      whole_q      <= '0;
      frac_q       <= '0;
      fcnt_q       <= '0;
      failed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      whole_q      <= whole_d;
      frac_q       <= frac_d;
      fcnt_q       <= fcnt_d;
      failed_q     <= failed_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_err_q  <= out_err_d;
    out_ms_q   <= out_ms_d;
    skid_err_q <= skid_err_d;
    skid_ms_q  <= skid_ms_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_ms_q;
  assign m_axis_tuser_o  = out_err_q;

endmodule

>>> hw/rtl/dsmp_checker.sv
// port-level checker for the decimal seconds to milliseconds parser
// depends on dsmp_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module dsmp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [dsmp_pkg::CharW-1:0] s_axis_tdata_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [dsmp_pkg::MsW-1:0]   m_axis_tdata_o,
  input logic                       m_axis_tuser_o
);
  import dsmp_pkg::*;

  logic         term_beat;
  logic         out_stall;
  logic [MsW:0] out_word;
  assign term_beat = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i == CharNul);
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word  = {m_axis_tuser_o, m_axis_tdata_o};

  // an error result carries zero milliseconds
  `ASSERT_IMP(a_err_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0)

  // a stalled result beat holds
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

  // a result appears only after a terminator beat
  `ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !m_axis_tvalid_o && !term_beat, !m_axis_tvalid_o)

  // a terminator into an empty output shows up next cycle
  `ASSERT_NXT(a_term_result, clk_i, rst_ni, !m_axis_tvalid_o && term_beat, m_axis_tvalid_o)

  // backpressure only while a result is pending
  `ASSERT_IMP(a_ready_low, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o)

endmodule

bind decimal_seconds_to_ms_parser dsmp_checker u_dsmp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
